### rtl/swsel_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the weighted sum-tree select block.
package swsel_pkg;

  // Request field widths
  localparam int LEAF_IDX_W = 3;
  localparam int WEIGHT_W   = 32;
  localparam int TARGET_W   = 35;
  localparam int TOTAL_W    = 35;

  // Packed stream widths, padded to whole bytes
  localparam int S_TDATA_W  = 72;
  localparam int M_TDATA_W  = 40;

  typedef enum logic {
    OP_SET    = 1'b0,
    OP_SELECT = 1'b1
  } op_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic set_leaf;
    logic set_up;
    logic sel_step;
    logic emit;
  } swsel_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_sel;
    logic in_oor;
    logic in_leaf_ok;
    logic parent_is_root;
    logic next_is_leaf;
    logic out_free;
  } swsel_sts_t;

endpackage

### rtl/swsel_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the clearing pass, path updates, descents and results.
module swsel_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  swsel_pkg::swsel_sts_t sts,
  output swsel_pkg::swsel_cmd_t cmd
);
  import swsel_pkg::*;

  typedef enum logic [5:0] {
    CLEAR    = 6'b000001,
    IDLE     = 6'b000010,
    SET_LEAF = 6'b000100,
    SET_UP   = 6'b001000,
    SEL_DOWN = 6'b010000,
    RESULT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = IDLE;
        end
      end
      IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (sts.in_sel) begin
            state_next = sts.in_oor ? RESULT : SEL_DOWN;
          end else begin
            state_next = sts.in_leaf_ok ? SET_LEAF : RESULT;
          end
        end
      end
      SET_LEAF: begin
        cmd.set_leaf = 1'b1;
        state_next   = SET_UP;
      end
      SET_UP: begin
        cmd.set_up = 1'b1;
        if (sts.parent_is_root) begin
          state_next = RESULT;
        end
      end
      SEL_DOWN: begin
        cmd.sel_step = 1'b1;
        if (sts.next_is_leaf) begin
          state_next = RESULT;
        end
      end
      RESULT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = CLEAR;
      end
    endcase
  end

endmodule

### rtl/swsel_dp.sv
`timescale 1ns / 1ps
// Datapath: node-sum memory, path adder, descent compare and output register.
module swsel_dp #(
  parameter int LEAVES      = 8,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [swsel_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  output logic [swsel_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  swsel_pkg::swsel_cmd_t          cmd,
  output swsel_pkg::swsel_sts_t          sts
);
  import swsel_pkg::*;

  localparam int NODE_COUNT = 2 * LEAVES - 1;
  localparam int FIRST_LEAF = LEAVES - 1;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int SUM_W      = WEIGHT_BITS + $clog2(LEAVES);
  localparam int CMP_W      = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;
  localparam logic [SUM_W-1:0]  WMASK  = SUM_W'({WEIGHT_BITS{1'b1}});
  localparam logic [NODE_W-1:0] FL_IDX = NODE_W'(FIRST_LEAF);
  localparam int M_PAD_W    = M_TDATA_W - LEAF_IDX_W - TOTAL_W;

  // Unpacked request fields
  logic [LEAF_IDX_W-1:0] in_leaf;
  logic [WEIGHT_W-1:0]   in_weight;
  logic [TARGET_W-1:0]   in_target;

  assign in_leaf   = s_tdata[LEAF_IDX_W-1:0];
  assign in_weight = s_tdata[LEAF_IDX_W +: WEIGHT_W];
  assign in_target = s_tdata[LEAF_IDX_W + WEIGHT_W +: TARGET_W];

  // Node-sum memory
  logic [SUM_W-1:0]  mem [NODE_COUNT];
  logic [SUM_W-1:0]  rdata;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  logic [SUM_W-1:0]  wr_data;
  logic [NODE_W-1:0] rd_addr;

  // Working registers
  logic [NODE_W-1:0] node;
  logic [CMP_W-1:0]  t;
  logic [SUM_W-1:0]  cur;
  logic [SUM_W-1:0]  total;
  logic              oor;
  logic              is_sel;
  logic [NODE_W-1:0] clr_addr;

  // Result register
  logic [LEAF_IDX_W-1:0] res_leaf;
  logic [TOTAL_W-1:0]    res_total;

  // Path arithmetic
  logic [NODE_W-1:0] parent;
  logic [NODE_W-1:0] sib_node;
  logic [NODE_W-1:0] sib_parent;
  logic [SUM_W-1:0]  path_sum;
  logic [CMP_W-1:0]  left;
  logic              go_left;
  logic [NODE_W-1:0] lchild;
  logic [NODE_W-1:0] nn;
  logic [NODE_W-1:0] nn_lchild;
  logic              in_sel;
  logic [NODE_W-1:0] in_node;
  logic [SUM_W-1:0]  in_w;
  logic [LEAF_IDX_W-1:0] leaf_out;

  assign in_sel   = (op_t'(s_tuser) == OP_SELECT);
  assign in_node  = NODE_W'(32'(in_leaf) + 32'(FIRST_LEAF));
  assign in_w     = SUM_W'(in_weight) & WMASK;

  assign parent     = (node - NODE_W'(1)) >> 1;
  assign sib_node   = node[0] ? node + NODE_W'(1) : node - NODE_W'(1);
  assign sib_parent = parent[0] ? parent + NODE_W'(1) : parent - NODE_W'(1);
  assign path_sum   = cur + rdata;

  assign left      = CMP_W'(rdata);
  assign go_left   = (t <= left);
  assign lchild    = NODE_W'({node, 1'b1});
  assign nn        = go_left ? lchild : lchild + NODE_W'(1);
  assign nn_lchild = NODE_W'({nn, 1'b1});

  always_comb begin
    sts                = '0;
    sts.clr_last       = (clr_addr == NODE_W'(NODE_COUNT - 1));
    sts.in_sel         = in_sel;
    sts.in_oor         = (CMP_W'(in_target) > CMP_W'(total));
    sts.in_leaf_ok     = (32'(in_leaf) < 32'(LEAVES));
    sts.parent_is_root = (parent == '0);
    sts.next_is_leaf   = (nn >= FL_IDX);
    sts.out_free       = !m_tvalid || m_tready;
  end

  // Single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    priority if (cmd.clear) begin
      wr_en = 1'b1;
    end else if (cmd.set_leaf) begin
      wr_en   = 1'b1;
      wr_addr = node;
      wr_data = cur;
    end else if (cmd.set_up) begin
      wr_en   = 1'b1;
      wr_addr = parent;
      wr_data = path_sum;
    end else begin
      wr_en = 1'b0;
    end
  end

  // Read address for the sum needed in the next cycle
  always_comb begin
    rd_addr = '0;
    priority if (cmd.load) begin
      rd_addr = NODE_W'(1);
    end else if (cmd.set_leaf) begin
      rd_addr = sib_node;
    end else if (cmd.set_up) begin
      rd_addr = (parent != '0) ? sib_parent : '0;
    end else if (cmd.sel_step) begin
      rd_addr = (nn < FL_IDX) ? nn_lchild : '0;
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      total    <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + NODE_W'(1);
      end
      if (cmd.set_up && parent == '0) begin
        total <= path_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node   <= in_sel ? '0 : in_node;
      t      <= CMP_W'(in_target);
      cur    <= in_w;
      is_sel <= in_sel;
      oor    <= in_sel && (CMP_W'(in_target) > CMP_W'(total));
    end else if (cmd.set_up) begin
      node <= parent;
      cur  <= path_sum;
    end else if (cmd.sel_step) begin
      node <= nn;
      // subtract the left sum when stepping right
      if (!go_left) begin
        t <= t - left;
      end
    end
  end

  always_comb begin
    if (!is_sel) begin
      leaf_out = '0;
    end else if (oor) begin
      leaf_out = LEAF_IDX_W'(LEAVES - 1);
    end else begin
      leaf_out = LEAF_IDX_W'(node - FL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_leaf  <= leaf_out;
      res_total <= TOTAL_W'(total);
      m_tuser   <= oor;
    end
  end

  assign m_tdata = {{M_PAD_W{1'b0}}, res_total, res_leaf};

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("result register not marked valid after emit");

  a_oor_last_leaf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> res_leaf == LEAF_IDX_W'(LEAVES - 1))
    else $error("out-of-range result does not name the last leaf");

  a_descent_in_tree: assert property (@(posedge clk) disable iff (rst)
    cmd.sel_step |=> node < NODE_W'(NODE_COUNT))
    else $error("descent left the tree");

endmodule

### rtl/sum_tree_weighted_select.sv
`timescale 1ns / 1ps
// Top level of the weighted sum-tree select block.
//
// Keeps LEAVES weights in a binary sum tree held in a single-port-write,
// registered-read memory and walks one tree level per clock. After reset a
// clearing pass writes zero to all 2*LEAVES-1 nodes, one per cycle, with
// s_tready low. A set request runs from acceptance through one leaf write,
// one add-and-write per level up to the root and a result state. A select
// request runs through one compare per level down and a result state; a
// target above the total or a set to a leaf beyond the tree goes straight
// to the result state, which waits until the output register is free. One
// request is in work at a time, and a finished result waits in the output
// register while the next request is taken.
module sum_tree_weighted_select #(
  parameter int LEAVES      = 8,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // leaf_index[2:0], weight[34:3], target[69:35], zero pad[71:70]
  input  logic [swsel_pkg::S_TDATA_W-1:0] s_tdata,
  // op[0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // selected_leaf[2:0], total_weight[37:3], zero pad[39:38]
  output logic [swsel_pkg::M_TDATA_W-1:0] m_tdata,
  // out_of_range[0]
  output logic                           m_tuser
);
  import swsel_pkg::*;

  swsel_cmd_t cmd;
  swsel_sts_t sts;

  swsel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swsel_dp #(
    .LEAVES      (LEAVES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

### sim/sum_tree_weighted_select_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the weighted sum-tree select block: directed table, then random.
module sum_tree_weighted_select_tb;
  import swsel_pkg::*;

  localparam int NUM_LEAVES   = 8;
  localparam int NODE_COUNT   = 2 * NUM_LEAVES - 1;
  localparam int FIRST_LEAF   = NUM_LEAVES - 1;
  localparam int DIR_ROWS     = 25;
  localparam int RAND_REQS    = 552;
  localparam int SEGMENTS     = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [TARGET_W-1:0] TARGET_MAX = '1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

  typedef struct packed {
    logic [LEAF_IDX_W-1:0] leaf;
    logic [TOTAL_W-1:0]    total;
    logic                  oor;
  } pick_t;

  typedef struct packed {
    op_t                   op;
    logic [LEAF_IDX_W-1:0] leaf;
    logic [WEIGHT_W-1:0]   weight;
    logic [TARGET_W-1:0]   target;
    logic                  typed;
    pick_t                 pick;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  logic [TOTAL_W-1:0] tree_sums [NODE_COUNT];
  pick_t              expected_picks [$];
  int                 mismatches = 0;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 cycle_count = 0;

  // Rows with typed = 1 carry a result that can be read straight off the tree contents.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_SELECT, 3'd0, 32'd0, 35'd0, 1'b1, '{3'd0, 35'd0, 1'b0}},
    '{OP_SELECT, 3'd0, 32'd0, 35'd1, 1'b1, '{3'd7, 35'd0, 1'b1}},
    '{OP_SELECT, 3'd0, 32'd0, 35'h7FFFFFFFF, 1'b1, '{3'd7, 35'd0, 1'b1}},
    '{OP_SET, 3'd0, 32'd0, 35'd0, 1'b1, '{3'd0, 35'd0, 1'b0}},
    '{OP_SET, 3'd7, 32'hFFFFFFFF, 35'd0, 1'b1, '{3'd0, 35'h0FFFFFFFF, 1'b0}},
    '{OP_SELECT, 3'd0, 32'd0, 35'd0, 1'b0, '0},
    '{OP_SELECT, 3'd0, 32'd0, 35'h0FFFFFFFF, 1'b0, '0},
    '{OP_SELECT, 3'd0, 32'd0, 35'h100000000, 1'b1, '{3'd7, 35'h0FFFFFFFF, 1'b1}},
    '{OP_SET, 3'd0, 32'hFFFFFFFF, 35'd0, 1'b0, '0},
    '{OP_SET, 3'd1, 32'hFFFFFFFF, 35'd0, 1'b0, '0},
    '{OP_SET, 3'd2, 32'hFFFFFFFF, 35'd0, 1'b0, '0},
    '{OP_SET, 3'd3, 32'hFFFFFFFF, 35'd0, 1'b0, '0},
    '{OP_SET, 3'd4, 32'hFFFFFFFF, 35'd0, 1'b0, '0},
    '{OP_SET, 3'd5, 32'hFFFFFFFF, 35'd0, 1'b0, '0},
    '{OP_SET, 3'd6, 32'hFFFFFFFF, 35'd0, 1'b0, '0},
    '{OP_SELECT, 3'd0, 32'd0, 35'h7FFFFFFFF, 1'b1, '{3'd7, 35'h7FFFFFFF8, 1'b1}},
    '{OP_SELECT, 3'd0, 32'd0, 35'h7FFFFFFF8, 1'b0, '0},
    '{OP_SELECT, 3'd0, 32'd0, 35'h0FFFFFFFF, 1'b0, '0},
    '{OP_SELECT, 3'd0, 32'd0, 35'h100000000, 1'b0, '0},
    '{OP_SET, 3'd3, 32'd0, 35'd0, 1'b0, '0},
    '{OP_SELECT, 3'd0, 32'd0, 35'h2FFFFFFFD, 1'b0, '0},
    '{OP_SELECT, 3'd0, 32'd0, 35'h2FFFFFFFE, 1'b0, '0},
    '{OP_SET, 3'd0, 32'd1, 35'd0, 1'b0, '0},
    '{OP_SELECT, 3'd0, 32'd0, 35'd1, 1'b0, '0},
    '{OP_SELECT, 3'd0, 32'd0, 35'd2, 1'b0, '0}
  };

  sum_tree_weighted_select #(
    .LEAVES     (NUM_LEAVES),
    .WEIGHT_BITS(WEIGHT_W)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Update the tree for one request and work out the result it should produce.
  function automatic pick_t apply_request(op_t op, logic [LEAF_IDX_W-1:0] leaf,
                                          logic [WEIGHT_W-1:0] weight,
                                          logic [TARGET_W-1:0] target);
    int                 node;
    logic [TOTAL_W-1:0] rest;
    pick_t              res;
    res = '0;
    if (op == OP_SET) begin
      if (leaf < NUM_LEAVES) begin
        node = FIRST_LEAF + leaf;
        tree_sums[node] = TOTAL_W'(weight);
        while (node > 0) begin
          node = (node - 1) / 2;
          tree_sums[node] = tree_sums[2 * node + 1] + tree_sums[2 * node + 2];
        end
      end
    end else if (target > tree_sums[0]) begin
      res.oor  = 1'b1;
      res.leaf = LEAF_IDX_W'(FIRST_LEAF);
    end else begin
      // Ties go left, so a zero target lands on the leftmost leaf.
      rest = target;
      node = 0;
      while (node < FIRST_LEAF) begin
        if (rest <= tree_sums[2 * node + 1]) begin
          node = 2 * node + 1;
        end else begin
          rest = rest - tree_sums[2 * node + 1];
          node = 2 * node + 2;
        end
      end
      res.leaf = LEAF_IDX_W'(node - FIRST_LEAF);
    end
    res.total = tree_sums[0];
    return res;
  endfunction

  task automatic send_request(input op_t op, input logic [LEAF_IDX_W-1:0] leaf,
                              input logic [WEIGHT_W-1:0] weight,
                              input logic [TARGET_W-1:0] target,
                              input logic typed, input pick_t typed_pick);
    pick_t res;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, target, weight, leaf};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = apply_request(op, leaf, weight, target);
    expected_picks.push_back(typed ? typed_pick : res);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    pick_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_picks.size() == 0) begin
        $error("unexpected result: leaf %0d total %0h oor %0b",
               m_tdata[2:0], m_tdata[37:3], m_tuser);
        mismatches++;
      end else begin
        want = expected_picks.pop_front();
        if (m_tdata[2:0] != want.leaf) begin
          $error("selected_leaf: expected %0d, got %0d", want.leaf, m_tdata[2:0]);
          mismatches++;
        end
        if (m_tdata[37:3] != want.total) begin
          $error("total_weight: expected %0h, got %0h", want.total, m_tdata[37:3]);
          mismatches++;
        end
        if (m_tuser != want.oor) begin
          $error("out_of_range: expected %0b, got %0b", want.oor, m_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    op_t                   op;
    logic [LEAF_IDX_W-1:0] leaf;
    logic [WEIGHT_W-1:0]   weight;
    logic [TARGET_W-1:0]   target;
    logic [63:0]           rnd;
    logic [63:0]           total;
    logic [63:0]           span;
    int                    k;
    foreach (tree_sums[i]) tree_sums[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].op, dir_rows[i].leaf, dir_rows[i].weight,
                   dir_rows[i].target, dir_rows[i].typed, dir_rows[i].pick);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int n = 0; n < RAND_REQS / SEGMENTS; n++) begin
        total = 64'(tree_sums[0]);
        rnd   = {$urandom, $urandom};
        leaf  = LEAF_IDX_W'($urandom_range(NUM_LEAVES - 1));
        if ($urandom_range(99) < 40) begin
          op     = OP_SET;
          target = TARGET_W'(rnd);
          case ($urandom_range(9))
            0, 1:    weight = '0;
            2:       weight = WEIGHT_MAX;
            3:       weight = WEIGHT_W'($urandom_range(255));
            4:       weight = 32'd1 << $urandom_range(WEIGHT_W - 1);
            default: weight = $urandom;
          endcase
        end else begin
          op     = OP_SELECT;
          weight = $urandom;
          case ($urandom_range(9))
            0: target = '0;
            1, 2: begin
              // hit a leaf boundary exactly, or one past it
              k    = $urandom_range(NUM_LEAVES);
              span = '0;
              for (int i = 0; i < k; i++) span += 64'(tree_sums[FIRST_LEAF + i]);
              target = TARGET_W'(span + 64'($urandom_range(1)));
            end
            3:       target = TARGET_W'(total + 1 + rnd % (64'(TARGET_MAX) - total));
            4:       target = TARGET_W'(rnd);
            default: target = TARGET_W'(rnd % (total + 1));
          endcase
        end
        send_request(op, leaf, weight, target, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    while (expected_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/swsel_pkg.sv
rtl/swsel_ctrl.sv
rtl/swsel_dp.sv
rtl/sum_tree_weighted_select.sv
sim/sum_tree_weighted_select_tb.sv
